### design/pkte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkte_pkg
// Operation codes and the control bundles shared by the peer key table engine.
// ----------------------------------------------------------------------------
package pkte_pkg;

  localparam logic [2:0] OP_ADD_NODE  = 3'd0;
  localparam logic [2:0] OP_DROP_NODE = 3'd1;
  localparam logic [2:0] OP_ADD_WEAK  = 3'd2;
  localparam logic [2:0] OP_DROP_WEAK = 3'd3;
  localparam logic [2:0] OP_AUTH      = 3'd4;
  localparam logic [2:0] OP_ADDR      = 3'd5;
  localparam logic [2:0] OP_KEY       = 3'd6;
  localparam logic [2:0] OP_VALIDATE  = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic cmp;
    logic publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic immediate;
    logic finish;
  } sts_t;

endpackage
`default_nettype wire

### design/pkte_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkte_ctrl
// Sequencer: accepts a beat, steps the table scan and hands off the result.
// ----------------------------------------------------------------------------
module pkte_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pkte_pkg::cmd_t      cmd,
  input  wire pkte_pkg::sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready    = (state == S_IDLE);
  assign cmd.start   = in_valid && in_ready;
  assign cmd.cmp     = (state == S_CMP);
  assign cmd.publish = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.start) state_next = sts.immediate ? S_DONE : S_READ;
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        state_next = sts.finish ? S_DONE : S_READ;
      end
      S_DONE: begin
        if (cmd.publish) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### design/pkte_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkte_datapath
// The three tables, the scan index, the match logic and the result registers.
// ----------------------------------------------------------------------------
module pkte_datapath #(
  parameter int TABLE_ENTRIES = 16,
  parameter int SERIAL_BYTES  = 8,
  parameter int ADDR_BITS     = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pkte_pkg::cmd_t cmd,
  output pkte_pkg::sts_t      sts,
  input  wire logic [2:0]     kind,
  input  wire logic [63:0]    serial_in,
  input  wire logic [63:0]    auth_high,
  input  wire logic [63:0]    auth_low,
  input  wire logic [63:0]    key_high,
  input  wire logic [63:0]    key_low,
  input  wire logic [15:0]    peer_addr,
  output logic                ok,
  output logic [63:0]         serial_out,
  output logic [63:0]         key_out_high,
  output logic [63:0]         key_out_low
);

  localparam int N  = TABLE_ENTRIES;
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int SW = 8 * SERIAL_BYTES;
  localparam int AW = (ADDR_BITS < 16) ? ADDR_BITS : 16;
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  // Latched operation.
  logic [2:0]    op;
  logic [SW-1:0] sn;
  logic [63:0]   ah, al, kh, kl;
  logic [AW-1:0] addr;
  logic          phase;
  logic [IW-1:0] idx, link, wslot, pslot;

  logic [N-1:0] node_used, node_checked, weak_used, peer_used;

  logic [SW-1:0] node_serial_mem    [N];
  logic [63:0]   node_auth_high_mem [N];
  logic [63:0]   node_auth_low_mem  [N];
  logic [AW-1:0] weak_address_mem   [N];
  logic [63:0]   weak_key_high_mem  [N];
  logic [63:0]   weak_key_low_mem   [N];
  logic [AW-1:0] peer_address_mem   [N];
  logic [IW-1:0] peer_node_index_mem[N];
  logic [63:0]   peer_key_high_mem  [N];
  logic [63:0]   peer_key_low_mem   [N];

  logic [SW-1:0] node_serial_q;
  logic [63:0]   node_auth_high_q, node_auth_low_q;
  logic [AW-1:0] weak_address_q;
  logic [63:0]   weak_key_high_q, weak_key_low_q;
  logic [AW-1:0] peer_address_q;
  logic [IW-1:0] peer_node_index_q;
  logic [63:0]   peer_key_high_q, peer_key_low_q;

  logic          res_ok;
  logic [SW-1:0] res_serial;
  logic [63:0]   res_key_high, res_key_low;

  logic [IW-1:0] free_node, free_weak, free_peer;
  logic          free_node_any, free_weak_any, free_peer_any;

  // Lowest free slot of each table; scanning downward leaves the lowest.
  always_comb begin
    free_node = '0;
    free_weak = '0;
    free_peer = '0;
    free_node_any = 1'b0;
    free_weak_any = 1'b0;
    free_peer_any = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!node_used[i]) begin
        free_node = IW'(i);
        free_node_any = 1'b1;
      end
      if (!weak_used[i]) begin
        free_weak = IW'(i);
        free_weak_any = 1'b1;
      end
      if (!peer_used[i]) begin
        free_peer = IW'(i);
        free_peer_any = 1'b1;
      end
    end
  end

  logic node_ser_eq, auth_eq, weak_addr_eq, weak_full_eq;
  logic peer_addr_eq, peer_key_eq, peer_link_eq;
  logic hit, last, need_p2;

  assign node_ser_eq  = node_used[idx] && (node_serial_q == sn);
  assign auth_eq      = node_used[idx] && (node_auth_high_q == ah) && (node_auth_low_q == al);
  assign weak_addr_eq = weak_used[idx] && (weak_address_q == addr);
  assign weak_full_eq = weak_addr_eq && (weak_key_high_q == kh) && (weak_key_low_q == kl);
  assign peer_addr_eq = peer_used[idx] && (peer_address_q == addr);
  assign peer_key_eq  = peer_used[idx] && (peer_key_high_q == kh) && (peer_key_low_q == kl);
  assign peer_link_eq = peer_used[idx] && (peer_node_index_q == link);
  assign last         = (idx == LAST);
  assign need_p2      = !phase && ((op == pkte_pkg::OP_AUTH) || (op == pkte_pkg::OP_KEY) ||
                                   (op == pkte_pkg::OP_VALIDATE));

  always_comb begin
    hit = 1'b0;
    if (!phase) begin
      case (op)
        pkte_pkg::OP_DROP_NODE: hit = node_ser_eq;
        pkte_pkg::OP_DROP_WEAK: hit = weak_addr_eq;
        pkte_pkg::OP_AUTH:      hit = auth_eq;
        pkte_pkg::OP_ADDR:      hit = peer_addr_eq || weak_addr_eq;
        pkte_pkg::OP_KEY:       hit = peer_key_eq;
        pkte_pkg::OP_VALIDATE:  hit = weak_full_eq;
        default:                hit = 1'b0;
      endcase
    end else begin
      case (op)
        pkte_pkg::OP_AUTH:     hit = peer_link_eq;
        pkte_pkg::OP_KEY:      hit = 1'b1;
        pkte_pkg::OP_VALIDATE: hit = node_ser_eq && !node_checked[idx];
        default:               hit = 1'b0;
      endcase
    end
  end

  assign sts.immediate = (kind == pkte_pkg::OP_ADD_NODE) || (kind == pkte_pkg::OP_ADD_WEAK) ||
                         ((kind == pkte_pkg::OP_VALIDATE) && !free_peer_any);
  assign sts.finish    = cmd.cmp && ((hit && !need_p2) || (!hit && last));

  // Control state, flags and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_used    <= '0;
      node_checked <= '0;
      weak_used    <= '0;
      peer_used    <= '0;
      phase        <= 1'b0;
      idx          <= '0;
      res_ok       <= 1'b0;
    end else begin
      if (cmd.start) begin
        phase        <= 1'b0;
        idx          <= '0;
        res_ok       <= ((kind == pkte_pkg::OP_ADD_NODE) && free_node_any) ||
                        ((kind == pkte_pkg::OP_ADD_WEAK) && free_weak_any);
        res_serial   <= '0;
        res_key_high <= '0;
        res_key_low  <= '0;
        pslot        <= free_peer;
        if (kind == pkte_pkg::OP_ADD_NODE && free_node_any) begin
          node_used[free_node] <= 1'b1;
        end
        if (kind == pkte_pkg::OP_ADD_WEAK && free_weak_any) begin
          weak_used[free_weak] <= 1'b1;
        end
      end
      if (cmd.cmp) begin
        if (hit) begin
          if (!phase) begin
            case (op)
              pkte_pkg::OP_DROP_NODE: begin
                node_used[idx] <= 1'b0;
                res_ok <= 1'b1;
              end
              pkte_pkg::OP_DROP_WEAK: begin
                weak_used[idx] <= 1'b0;
                res_ok <= 1'b1;
              end
              pkte_pkg::OP_AUTH: begin
                res_serial <= node_serial_q;
                res_ok <= 1'b1;
                link <= idx;
              end
              pkte_pkg::OP_ADDR: begin
                res_ok <= 1'b1;
                // The validated peer takes precedence within one slot.
                res_key_high <= peer_addr_eq ? peer_key_high_q : weak_key_high_q;
                res_key_low  <= peer_addr_eq ? peer_key_low_q : weak_key_low_q;
              end
              pkte_pkg::OP_KEY: res_ok <= 1'b1;
              pkte_pkg::OP_VALIDATE: wslot <= idx;
              default: ;
            endcase
            if (need_p2) begin
              phase <= 1'b1;
              idx   <= (op == pkte_pkg::OP_KEY) ? peer_node_index_q : '0;
            end
          end else begin
            case (op)
              pkte_pkg::OP_KEY: res_serial <= node_serial_q;
              pkte_pkg::OP_VALIDATE: begin
                peer_used[pslot]  <= 1'b1;
                weak_used[wslot]  <= 1'b0;
                node_checked[idx] <= 1'b1;
                res_ok <= 1'b1;
              end
              default: ;
            endcase
          end
        end else if (!last) begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // Table storage with registered reads at the scan index.
  always_ff @(posedge clk) begin
    if (cmd.start && kind == pkte_pkg::OP_ADD_NODE && free_node_any) begin
      node_serial_mem[free_node]    <= serial_in[SW-1:0];
      node_auth_high_mem[free_node] <= auth_high;
      node_auth_low_mem[free_node]  <= auth_low;
    end
    if (cmd.start && kind == pkte_pkg::OP_ADD_WEAK && free_weak_any) begin
      weak_address_mem[free_weak]  <= peer_addr[AW-1:0];
      weak_key_high_mem[free_weak] <= key_high;
      weak_key_low_mem[free_weak]  <= key_low;
    end
    if (cmd.cmp && hit && phase && op == pkte_pkg::OP_AUTH) begin
      peer_address_mem[idx] <= addr;
    end
    if (cmd.cmp && hit && phase && op == pkte_pkg::OP_VALIDATE) begin
      peer_address_mem[pslot]    <= addr;
      peer_node_index_mem[pslot] <= idx;
      peer_key_high_mem[pslot]   <= kh;
      peer_key_low_mem[pslot]    <= kl;
    end
    node_serial_q     <= node_serial_mem[idx];
    node_auth_high_q  <= node_auth_high_mem[idx];
    node_auth_low_q   <= node_auth_low_mem[idx];
    weak_address_q    <= weak_address_mem[idx];
    weak_key_high_q   <= weak_key_high_mem[idx];
    weak_key_low_q    <= weak_key_low_mem[idx];
    peer_address_q    <= peer_address_mem[idx];
    peer_node_index_q <= peer_node_index_mem[idx];
    peer_key_high_q   <= peer_key_high_mem[idx];
    peer_key_low_q    <= peer_key_low_mem[idx];
  end

  // Operand capture and the output register.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op   <= kind;
      sn   <= serial_in[SW-1:0];
      ah   <= auth_high;
      al   <= auth_low;
      kh   <= key_high;
      kl   <= key_low;
      addr <= peer_addr[AW-1:0];
    end
    if (cmd.publish) begin
      ok           <= res_ok;
      serial_out   <= 64'(res_serial);
      key_out_high <= res_key_high;
      key_out_low  <= res_key_low;
    end
  end

endmodule
`default_nettype wire

### design/peer_key_table_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// peer_key_table_engine
// Known-node, weak-peer and validated-peer tables with one result per beat.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. Add node, add weak peer and a validate
// that finds the peer table full skip the scan and go from acceptance straight
// to the done state. The searching operations visit one slot per read and
// compare state pair, since each table is read through a registered port at
// the scan index: a single search covers up to TABLE_ENTRIES slots, and the
// two-step ones (auth lookup, validate) scan a second table after a hit; key
// lookup adds one read and compare of the linked node. A finished result waits
// in the output register while the next beat is taken.
module peer_key_table_engine #(
  parameter int TABLE_ENTRIES = 16,
  parameter int SERIAL_BYTES  = 8,
  parameter int ADDR_BITS     = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  kind,
  input  wire logic [63:0] serial_in,
  input  wire logic [63:0] auth_high,
  input  wire logic [63:0] auth_low,
  input  wire logic [63:0] key_high,
  input  wire logic [63:0] key_low,
  input  wire logic [15:0] peer_addr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             ok,
  output logic [63:0]      serial_out,
  output logic [63:0]      key_out_high,
  output logic [63:0]      key_out_low
);

  pkte_pkg::cmd_t cmd;
  pkte_pkg::sts_t sts;

  pkte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  pkte_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .SERIAL_BYTES  (SERIAL_BYTES),
    .ADDR_BITS     (ADDR_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .serial_in    (serial_in),
    .auth_high    (auth_high),
    .auth_low     (auth_low),
    .key_high     (key_high),
    .key_low      (key_low),
    .peer_addr    (peer_addr),
    .ok           (ok),
    .serial_out   (serial_out),
    .key_out_high (key_out_high),
    .key_out_low  (key_out_low)
  );

  // Only one operation is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("beat accepted while an operation was in progress");

  // Reset leaves no stale result on the output.
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

### sim/peer_key_table_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_key_table_engine_tb
// Drives random and directed table operations into the peer key table engine
// and checks every result beat against a cycle-free model of the three tables.
// ----------------------------------------------------------------------------
module peer_key_table_engine_tb;

  localparam int ENTRIES = 16;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] serial;
    logic [63:0] auth_hi;
    logic [63:0] auth_lo;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [15:0] addr;
  } op_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] serial;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] kind = '0;
  logic [63:0] serial_in = '0, auth_high = '0, auth_low = '0;
  logic [63:0] key_high = '0, key_low = '0;
  logic [15:0] peer_addr = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic ok;
  logic [63:0] serial_out, key_out_high, key_out_low;

  peer_key_table_engine dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .serial_in(serial_in), .auth_high(auth_high),
    .auth_low(auth_low), .key_high(key_high), .key_low(key_low),
    .peer_addr(peer_addr), .out_valid(out_valid), .out_ready(out_ready),
    .ok(ok), .serial_out(serial_out), .key_out_high(key_out_high),
    .key_out_low(key_out_low)
  );

  // Shadow copy of the tables.
  logic        nd_used [ENTRIES], nd_checked [ENTRIES];
  logic [63:0] nd_serial [ENTRIES], nd_auth_hi [ENTRIES], nd_auth_lo [ENTRIES];
  logic        wk_used [ENTRIES];
  logic [15:0] wk_addr [ENTRIES];
  logic [63:0] wk_key_hi [ENTRIES], wk_key_lo [ENTRIES];
  logic        pr_used [ENTRIES];
  logic [15:0] pr_addr [ENTRIES];
  logic [3:0]  pr_node [ENTRIES];
  logic [63:0] pr_key_hi [ENTRIES], pr_key_lo [ENTRIES];

  op_t  pending_ops[$];
  res_t expected_results[$];
  int   mismatches = 0;
  bit   no_idle = 1'b0;
  int   hold_off = 0;
  int   quiet_cycles = 0;

  // Pools of values reused so that lookups and drops actually hit.
  logic [63:0] serial_pool [8];
  logic [63:0] auth_pool [8];
  logic [63:0] key_pool [8];
  logic [15:0] addr_pool [8];

  function automatic res_t apply_table_op(op_t op);
    res_t r;
    int free_slot;
    bit placed;
    r = '0;
    case (op.kind)
      pkte_pkg::OP_ADD_NODE: begin
        for (int i = 0; i < ENTRIES && !r.ok; i++) begin
          if (!nd_used[i]) begin
            nd_used[i] = 1; nd_serial[i] = op.serial;
            nd_auth_hi[i] = op.auth_hi; nd_auth_lo[i] = op.auth_lo; r.ok = 1;
          end
        end
      end
      pkte_pkg::OP_DROP_NODE: begin
        for (int i = 0; i < ENTRIES && !r.ok; i++) begin
          if (nd_used[i] && nd_serial[i] == op.serial) begin
            nd_used[i] = 0; r.ok = 1;
          end
        end
      end
      pkte_pkg::OP_ADD_WEAK: begin
        for (int i = 0; i < ENTRIES && !r.ok; i++) begin
          if (!wk_used[i]) begin
            wk_used[i] = 1; wk_addr[i] = op.addr;
            wk_key_hi[i] = op.key_hi; wk_key_lo[i] = op.key_lo; r.ok = 1;
          end
        end
      end
      pkte_pkg::OP_DROP_WEAK: begin
        for (int i = 0; i < ENTRIES && !r.ok; i++) begin
          if (wk_used[i] && wk_addr[i] == op.addr) begin
            wk_used[i] = 0; r.ok = 1;
          end
        end
      end
      pkte_pkg::OP_AUTH: begin
        for (int i = 0; i < ENTRIES && !r.ok; i++) begin
          if (nd_used[i] && nd_auth_hi[i] == op.auth_hi && nd_auth_lo[i] == op.auth_lo) begin
            r.serial = nd_serial[i]; r.ok = 1;
            placed = 0;
            for (int k = 0; k < ENTRIES && !placed; k++) begin
              if (pr_used[k] && pr_node[k] == i) begin
                pr_addr[k] = op.addr; placed = 1;
              end
            end
          end
        end
      end
      pkte_pkg::OP_ADDR: begin
        for (int i = 0; i < ENTRIES && !r.ok; i++) begin
          if (pr_used[i] && pr_addr[i] == op.addr) begin
            r.key_hi = pr_key_hi[i]; r.key_lo = pr_key_lo[i]; r.ok = 1;
          end else if (wk_used[i] && wk_addr[i] == op.addr) begin
            r.key_hi = wk_key_hi[i]; r.key_lo = wk_key_lo[i]; r.ok = 1;
          end
        end
      end
      pkte_pkg::OP_KEY: begin
        for (int i = 0; i < ENTRIES && !r.ok; i++) begin
          if (pr_used[i] && pr_key_hi[i] == op.key_hi && pr_key_lo[i] == op.key_lo) begin
            r.serial = nd_serial[pr_node[i]]; r.ok = 1;
          end
        end
      end
      default: begin
        free_slot = -1;
        for (int k = ENTRIES - 1; k >= 0; k--) if (!pr_used[k]) free_slot = k;
        if (free_slot >= 0) begin
          for (int i = 0; i < ENTRIES && !r.ok; i++) begin
            if (wk_used[i] && wk_addr[i] == op.addr && wk_key_hi[i] == op.key_hi &&
                wk_key_lo[i] == op.key_lo) begin
              for (int j = 0; j < ENTRIES && !r.ok; j++) begin
                if (nd_used[j] && !nd_checked[j] && nd_serial[j] == op.serial) begin
                  pr_used[free_slot] = 1; pr_addr[free_slot] = op.addr;
                  pr_node[free_slot] = j[3:0];
                  pr_key_hi[free_slot] = op.key_hi; pr_key_lo[free_slot] = op.key_lo;
                  wk_used[i] = 0; nd_checked[j] = 1; r.ok = 1;
                end
              end
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic op_t make_op(logic [2:0] k, int p);
    op_t op;
    op.kind = k;
    op.serial = serial_pool[p]; op.auth_hi = auth_pool[p];
    op.auth_lo = ~auth_pool[p]; op.key_hi = key_pool[p];
    op.key_lo = key_pool[p] ^ 64'h5a5a; op.addr = addr_pool[p];
    return op;
  endfunction

  function automatic op_t random_op();
    op_t op;
    int p;
    p = $urandom_range(7);
    op = make_op(3'($urandom_range(7)), p);
    // Mostly pooled values, some noise in single fields.
    case ($urandom_range(9))
      0: op.serial = rand64();
      1: begin op.auth_hi = rand64(); op.auth_lo = rand64(); end
      2: begin op.key_hi = rand64(); op.key_lo = rand64(); end
      3: op.addr = 16'($urandom());
      default: ;
    endcase
    return op;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // hold the beat
    end else if (pending_ops.size() > 0 && (no_idle || $urandom_range(99) >= 23)) begin
      op_t op;
      op = pending_ops.pop_front();
      expected_results.push_back(apply_table_op(op));
      kind <= op.kind; serial_in <= op.serial; auth_high <= op.auth_hi;
      auth_low <= op.auth_lo; key_high <= op.key_hi; key_low <= op.key_lo;
      peer_addr <= op.addr;
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver ready, with one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || $urandom_range(99) >= 23;
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", {63'd0, ok}, 64'd0);
        end else begin
          res_t want;
          want = expected_results.pop_front();
          if (ok !== want.ok) report_mismatch("ok", {63'd0, ok}, {63'd0, want.ok});
          if (serial_out !== want.serial) report_mismatch("serial_out", serial_out, want.serial);
          if (key_out_high !== want.key_hi)
            report_mismatch("key_out_high", key_out_high, want.key_hi);
          if (key_out_low !== want.key_lo)
            report_mismatch("key_out_low", key_out_low, want.key_lo);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("peer_key_table_engine test failed");
      $finish;
    end
  end

  initial begin
    op_t op;
    for (int i = 0; i < ENTRIES; i++) begin
      nd_used[i] = 0; nd_checked[i] = 0; wk_used[i] = 0; pr_used[i] = 0;
    end
    for (int p = 0; p < 8; p++) begin
      serial_pool[p] = rand64(); auth_pool[p] = rand64();
      key_pool[p] = rand64(); addr_pool[p] = 16'($urandom());
    end
    serial_pool[0] = '0; serial_pool[1] = '1;
    auth_pool[0] = '0; auth_pool[1] = '1;
    key_pool[0] = '0; key_pool[1] = '1;
    addr_pool[0] = '0; addr_pool[1] = 16'hffff;

    // Directed: every operation in opcode order, starting on empty tables, then a full validate flow.
    for (int k = 0; k < 8; k++) pending_ops.push_back(make_op(3'(k), 0));
    pending_ops.push_back(make_op(pkte_pkg::OP_ADD_NODE, 1));
    pending_ops.push_back(make_op(pkte_pkg::OP_ADD_WEAK, 1));
    pending_ops.push_back(make_op(pkte_pkg::OP_ADDR, 1));
    pending_ops.push_back(make_op(pkte_pkg::OP_VALIDATE, 1));
    pending_ops.push_back(make_op(pkte_pkg::OP_VALIDATE, 1));
    pending_ops.push_back(make_op(pkte_pkg::OP_KEY, 1));
    op = make_op(pkte_pkg::OP_AUTH, 1); op.addr = 16'h1234;
    pending_ops.push_back(op);
    op = make_op(pkte_pkg::OP_ADDR, 1); op.addr = 16'h1234;
    pending_ops.push_back(op);
    pending_ops.push_back(make_op(pkte_pkg::OP_DROP_NODE, 1));
    pending_ops.push_back(make_op(pkte_pkg::OP_KEY, 1));
    pending_ops.push_back(make_op(pkte_pkg::OP_DROP_WEAK, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_ops.size() == 0);

    // Fill node and weak tables past full.
    for (int i = 0; i < ENTRIES + 2; i++) begin
      pending_ops.push_back(make_op(pkte_pkg::OP_ADD_NODE, i % 8));
      pending_ops.push_back(make_op(pkte_pkg::OP_ADD_WEAK, i % 8));
    end
    // Long receiver hold-off while the sender keeps offering.
    @(posedge clk);
    hold_off <= 400;
    wait (pending_ops.size() == 0);

    // Random phase; drops and validations keep the tables churning.
    for (int n = 0; n < 1150; n++) begin
      pending_ops.push_back(random_op());
      if (n == 300) begin
        wait (pending_ops.size() < 20);
        no_idle = 1;
      end
      if (n == 500) begin
        wait (pending_ops.size() < 20);
        no_idle = 0;
      end
    end
    wait (pending_ops.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("peer_key_table_engine test passed");
    end else begin
      $display("peer_key_table_engine test failed");
    end
    $finish;
  end
endmodule
